// ----- rtl/terrain_mass_balance_index_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the mass balance index block
// Shared property forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_MASS_BALANCE_INDEX_DEFINES_SVH
`define TERRAIN_MASS_BALANCE_INDEX_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define TMBI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmbi same-cycle check failed");

// Check that a condition holds in the cycle after its trigger
`define TMBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmbi next-cycle check failed");

`endif

// ----- rtl/tmbi_pkg.sv -----
// ----------------------------------------------------------------------------
// tmbi_pkg
// Types, constants and helpers shared by the mass balance index pipeline.
// ----------------------------------------------------------------------------
package tmbi_pkg;

    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned CORDIC_STEPS = 24;
    localparam int unsigned DIV_STEPS = 17;
    localparam int unsigned NUM_LANES = 3;

    localparam int unsigned LANE_SLOPE = 0;
    localparam int unsigned LANE_CURVE = 1;
    localparam int unsigned LANE_HREL = 2;

    // Configuration register indexes
    localparam logic [2:0] CFG_HREL_IN_USE     = 3'd0;
    localparam logic [2:0] CFG_SLOPE_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_CURVE_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_HREL_THRESHOLD  = 3'd3;
    localparam logic [2:0] CFG_INV_CELL_SIZE   = 3'd4;
    localparam logic [2:0] CFG_INV_CELL_AREA   = 3'd5;

    // Register reset values
    localparam logic        RST_HREL_IN_USE     = 1'b0;
    localparam logic [23:0] RST_SLOPE_THRESHOLD = 24'd983040;
    localparam logic [23:0] RST_CURVE_THRESHOLD = 24'd167772;
    localparam logic [23:0] RST_HREL_THRESHOLD  = 24'd61440;
    localparam logic [31:0] RST_INV_CELL_SIZE   = 32'd16777216;
    localparam logic [31:0] RST_INV_CELL_AREA   = 32'd16777216;

    localparam logic [30:0] MAG_CAP = '1;
    localparam logic [17:0] ONE_Q16 = 18'd65536;
    localparam logic signed [21:0] MBI_MAX = 22'sd262144;
    localparam logic signed [21:0] MBI_MIN = -22'sd262144;

    // Arctangent of 2^-i in Q2.30
    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    typedef struct packed {
        logic        hrel_in_use;
        logic [23:0] slope_thr;
        logic [23:0] curve_thr;
        logic [23:0] hrel_thr;
        logic [31:0] inv_cell_size;
        logic [31:0] inv_cell_area;
    } t_cfg;

    // Data that rides alongside the slope path
    typedef struct packed {
        logic        nodata;
        logic        curve_neg;
        logic [30:0] cm;
        logic [31:0] hv;
    } t_side;

    // Neighbour difference with mirroring of a missing side
    function automatic logic [32:0] elev_diff(
        input logic [31:0] c,
        input logic        nv,
        input logic [31:0] n,
        input logic        ov,
        input logic [31:0] o
    );
        logic [32:0] res;
        if (nv) begin
            res = {n[31], n} - {c[31], c};
        end else if (ov) begin
            res = {c[31], c} - {o[31], o};
        end else begin
            res = '0;
        end
        return res;
    endfunction

    function automatic logic [34:0] abs35(input logic [34:0] x);
        return x[34] ? (35'd0 - x) : x;
    endfunction

endpackage

// ----- rtl/terrain_mass_balance_index.sv -----
// Throughput: one cell per cycle while no shown result is stalled; the
// 32-stage root, 24-stage CORDIC and 18-stage divider pipelines set the
// depth, not the rate.
// Reset: synchronous; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// terrain_mass_balance_index
// Mass balance index of one elevation cell from its cardinal neighbours.
// ----------------------------------------------------------------------------
module terrain_mass_balance_index (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [31:0]  i_center_elev,
    input  logic                i_center_valid,
    input  logic signed [31:0]  i_north_elev,
    input  logic                i_north_valid,
    input  logic signed [31:0]  i_south_elev,
    input  logic                i_south_valid,
    input  logic signed [31:0]  i_east_elev,
    input  logic                i_east_valid,
    input  logic signed [31:0]  i_west_elev,
    input  logic                i_west_valid,
    input  logic signed [31:0]  i_hrel_value,
    input  logic                i_hrel_valid,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [19:0]  o_mbi_value,
    output logic                o_mbi_nodata,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

`include "terrain_mass_balance_index_defines.svh"

    tmbi_pkg::t_cfg  r_cfg;
    logic            w_en;

    logic            w_fr_valid, w_sq_valid, w_co_valid, w_dv_valid;
    logic [62:0]     w_sq;
    logic [31:0]     w_root;
    logic [17:0]     w_slope;
    tmbi_pkg::t_side w_fr_side, w_sq_side, w_co_side, w_dv_side;
    logic [tmbi_pkg::NUM_LANES-1:0][16:0] w_quot;

    logic [16:0]     w_qs, w_qc, w_qh;
    logic            w_hneg;
    logic [17:0]     n_b1_f1, n_b1_f2;
    logic [34:0]     r_b1_p1;
    logic [17:0]     r_b1_f2;
    logic            r_b1_neg, r_b1_nodata, r_b1_valid;

    logic [52:0]     w_p2;
    logic [20:0]     r_b2_mag;
    logic            r_b2_neg, r_b2_nodata, r_b2_valid;

    logic signed [21:0] w_res, w_sat;
    logic signed [19:0] r_out_value;
    logic               r_out_nodata, r_out_valid;

    // Advance the whole pipeline unless a shown result is held
    assign w_en        = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hrel_in_use   <= tmbi_pkg::RST_HREL_IN_USE;
            r_cfg.slope_thr     <= tmbi_pkg::RST_SLOPE_THRESHOLD;
            r_cfg.curve_thr     <= tmbi_pkg::RST_CURVE_THRESHOLD;
            r_cfg.hrel_thr      <= tmbi_pkg::RST_HREL_THRESHOLD;
            r_cfg.inv_cell_size <= tmbi_pkg::RST_INV_CELL_SIZE;
            r_cfg.inv_cell_area <= tmbi_pkg::RST_INV_CELL_AREA;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tmbi_pkg::CFG_HREL_IN_USE:     r_cfg.hrel_in_use   <= i_cfg_data[0];
                tmbi_pkg::CFG_SLOPE_THRESHOLD: r_cfg.slope_thr     <= i_cfg_data[23:0];
                tmbi_pkg::CFG_CURVE_THRESHOLD: r_cfg.curve_thr     <= i_cfg_data[23:0];
                tmbi_pkg::CFG_HREL_THRESHOLD:  r_cfg.hrel_thr      <= i_cfg_data[23:0];
                tmbi_pkg::CFG_INV_CELL_SIZE:   r_cfg.inv_cell_size <= i_cfg_data;
                tmbi_pkg::CFG_INV_CELL_AREA:   r_cfg.inv_cell_area <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tmbi_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_in_valid),
        .i_cfg          (r_cfg),
        .i_center_elev  (i_center_elev),
        .i_center_valid (i_center_valid),
        .i_north_elev   (i_north_elev),
        .i_north_valid  (i_north_valid),
        .i_south_elev   (i_south_elev),
        .i_south_valid  (i_south_valid),
        .i_east_elev    (i_east_elev),
        .i_east_valid   (i_east_valid),
        .i_west_elev    (i_west_elev),
        .i_west_valid   (i_west_valid),
        .i_hrel_value   (i_hrel_value),
        .i_hrel_valid   (i_hrel_valid),
        .o_valid        (w_fr_valid),
        .o_sq           (w_sq),
        .o_side         (w_fr_side)
    );

    tmbi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_sq    (w_sq),
        .i_side  (w_fr_side),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    tmbi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_root  (w_root),
        .i_side  (w_sq_side),
        .o_valid (w_co_valid),
        .o_slope (w_slope),
        .o_side  (w_co_side)
    );

    tmbi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_co_valid),
        .i_cfg   (r_cfg),
        .i_slope (w_slope),
        .i_side  (w_co_side),
        .o_valid (w_dv_valid),
        .o_quot  (w_quot),
        .o_side  (w_dv_side)
    );

    // Form the factors and the first product
    always_comb begin
        w_qs   = w_quot[tmbi_pkg::LANE_SLOPE];
        w_qc   = w_quot[tmbi_pkg::LANE_CURVE];
        w_qh   = w_quot[tmbi_pkg::LANE_HREL];
        w_hneg = r_cfg.hrel_in_use && w_dv_side.hv[31];
        n_b1_f1 = w_dv_side.curve_neg ? (tmbi_pkg::ONE_Q16 - {1'b0, w_qs})
                                      : (tmbi_pkg::ONE_Q16 + {1'b0, w_qs});
        n_b1_f2 = (w_dv_side.curve_neg ^ w_hneg) ? (tmbi_pkg::ONE_Q16 - {1'b0, w_qh})
                                                 : (tmbi_pkg::ONE_Q16 + {1'b0, w_qh});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (w_en) begin
            r_b1_valid <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_p1     <= {18'd0, w_qc} * {17'd0, n_b1_f1};
            r_b1_f2     <= n_b1_f2;
            r_b1_neg    <= w_dv_side.curve_neg;
            r_b1_nodata <= w_dv_side.nodata;
        end
    end

    // Second product, back to Q5.16
    assign w_p2 = {18'd0, r_b1_p1} * {35'd0, r_b1_f2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
        end else if (w_en) begin
            r_b2_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b2_mag    <= w_p2[52:32];
            r_b2_neg    <= r_b1_neg;
            r_b2_nodata <= r_b1_nodata;
        end
    end

    // Apply the sign, saturate and blank nodata cells
    always_comb begin
        w_res = r_b2_neg ? (22'sd0 - $signed({1'b0, r_b2_mag}))
                         : $signed({1'b0, r_b2_mag});
        if (r_b2_nodata) begin
            w_sat = '0;
        end else if (w_res > tmbi_pkg::MBI_MAX) begin
            w_sat = tmbi_pkg::MBI_MAX;
        end else if (w_res < tmbi_pkg::MBI_MIN) begin
            w_sat = tmbi_pkg::MBI_MIN;
        end else begin
            w_sat = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_value  <= w_sat[19:0];
            r_out_nodata <= r_b2_nodata;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mbi_value  = r_out_value;
    assign o_mbi_nodata = r_out_nodata;

    // Checks
    `TMBI_ASSERT_SAME(a_nodata_zero, i_clk, i_rst_n, o_out_valid && o_mbi_nodata, o_mbi_value == '0)
    `TMBI_ASSERT_SAME(a_value_range, i_clk, i_rst_n, o_out_valid, (o_mbi_value <= 20'sd262144) && (o_mbi_value >= -20'sd262144))
    `TMBI_ASSERT_SAME(a_stall_backs_up, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
    `TMBI_ASSERT_NEXT(a_out_follows_pipe, i_clk, i_rst_n, w_en && !r_b2_valid, !o_out_valid)

endmodule

// ----- rtl/tmbi_front.sv -----
// ----------------------------------------------------------------------------
// tmbi_front
// Differences, curvature and gradient scaling, and the squared gradient sum.
// ----------------------------------------------------------------------------
module tmbi_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  tmbi_pkg::t_cfg      i_cfg,
    input  logic signed [31:0]  i_center_elev,
    input  logic                i_center_valid,
    input  logic signed [31:0]  i_north_elev,
    input  logic                i_north_valid,
    input  logic signed [31:0]  i_south_elev,
    input  logic                i_south_valid,
    input  logic signed [31:0]  i_east_elev,
    input  logic                i_east_valid,
    input  logic signed [31:0]  i_west_elev,
    input  logic                i_west_valid,
    input  logic signed [31:0]  i_hrel_value,
    input  logic                i_hrel_valid,
    output logic                o_valid,
    output logic [62:0]         o_sq,
    output tmbi_pkg::t_side     o_side
);

    logic [32:0] w_dn, w_ds, w_de, w_dw;
    logic [34:0] n_f1_sum, n_f1_gx, n_f1_gy;
    logic [34:0] r_f1_sum, r_f1_gx, r_f1_gy;
    logic        r_f1_nodata;
    logic [31:0] r_f1_hv;
    logic        r_f1_valid;

    logic [34:0] w_asum, w_agx, w_agy;
    logic [66:0] w_pc, w_pg, w_ph;
    logic [30:0] n_f2_g, n_f2_h;
    tmbi_pkg::t_side n_f2_side;
    logic [30:0] r_f2_g, r_f2_h;
    tmbi_pkg::t_side r_f2_side;
    logic        r_f2_valid;

    logic [61:0] w_gg, w_hh;
    logic [62:0] r_f3_sq;
    tmbi_pkg::t_side r_f3_side;
    logic        r_f3_valid;

    // Form the differences, their sum and the opposite-pair differences
    always_comb begin
        w_dn = tmbi_pkg::elev_diff(i_center_elev, i_north_valid, i_north_elev,
                                   i_south_valid, i_south_elev);
        w_ds = tmbi_pkg::elev_diff(i_center_elev, i_south_valid, i_south_elev,
                                   i_north_valid, i_north_elev);
        w_de = tmbi_pkg::elev_diff(i_center_elev, i_east_valid, i_east_elev,
                                   i_west_valid, i_west_elev);
        w_dw = tmbi_pkg::elev_diff(i_center_elev, i_west_valid, i_west_elev,
                                   i_east_valid, i_east_elev);
        n_f1_sum = {{2{w_dn[32]}}, w_dn} + {{2{w_ds[32]}}, w_ds}
                 + {{2{w_de[32]}}, w_de} + {{2{w_dw[32]}}, w_dw};
        n_f1_gx = {{2{w_dn[32]}}, w_dn} - {{2{w_ds[32]}}, w_ds};
        n_f1_gy = {{2{w_de[32]}}, w_de} - {{2{w_dw[32]}}, w_dw};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (i_en) begin
            r_f1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_sum    <= n_f1_sum;
            r_f1_gx     <= n_f1_gx;
            r_f1_gy     <= n_f1_gy;
            r_f1_hv     <= i_hrel_value;
            r_f1_nodata <= !i_center_valid || (i_cfg.hrel_in_use && !i_hrel_valid);
        end
    end

    // Scale by the reciprocals and saturate the magnitudes
    always_comb begin
        w_asum = tmbi_pkg::abs35(r_f1_sum);
        w_agx  = tmbi_pkg::abs35(r_f1_gx);
        w_agy  = tmbi_pkg::abs35(r_f1_gy);
        w_pc = {32'd0, w_asum} * {35'd0, i_cfg.inv_cell_area};
        w_pg = {32'd0, w_agx} * {35'd0, i_cfg.inv_cell_size};
        w_ph = {32'd0, w_agy} * {35'd0, i_cfg.inv_cell_size};
        n_f2_side.cm = (|w_pc[66:43]) ? tmbi_pkg::MAG_CAP : w_pc[42:12];
        n_f2_g = (|w_pg[66:52]) ? tmbi_pkg::MAG_CAP : w_pg[51:21];
        n_f2_h = (|w_ph[66:52]) ? tmbi_pkg::MAG_CAP : w_ph[51:21];
        n_f2_side.curve_neg = !r_f1_sum[34] && (r_f1_sum != '0)
                            && (n_f2_side.cm != '0);
        n_f2_side.nodata = r_f1_nodata;
        n_f2_side.hv = r_f1_hv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else if (i_en) begin
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f2_g    <= n_f2_g;
            r_f2_h    <= n_f2_h;
            r_f2_side <= n_f2_side;
        end
    end

    // Square and add the gradients
    always_comb begin
        w_gg = {31'd0, r_f2_g} * {31'd0, r_f2_g};
        w_hh = {31'd0, r_f2_h} * {31'd0, r_f2_h};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_valid <= 1'b0;
        end else if (i_en) begin
            r_f3_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f3_sq   <= {1'b0, w_gg} + {1'b0, w_hh};
            r_f3_side <= r_f2_side;
        end
    end

    assign o_valid = r_f3_valid;
    assign o_sq    = r_f3_sq;
    assign o_side  = r_f3_side;

endmodule

// ----- rtl/tmbi_sqrt.sv -----
// ----------------------------------------------------------------------------
// tmbi_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tmbi_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [62:0]     i_sq,
    input  tmbi_pkg::t_side i_side,
    output logic            o_valid,
    output logic [31:0]     o_root,
    output tmbi_pkg::t_side o_side
);

    localparam int unsigned STEPS = tmbi_pkg::SQRT_STEPS;

    logic [63:0]       r_rem  [STEPS];
    logic [63:0]       r_root [STEPS];
    tmbi_pkg::t_side   r_side [STEPS];
    logic [STEPS-1:0]  r_v;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0]     p_rem, p_root, w_trial, n_rem, n_root;
        tmbi_pkg::t_side p_side;
        logic            p_v;

        if (k == 0) begin : g_first
            assign p_rem  = {1'b0, i_sq};
            assign p_root = '0;
            assign p_side = i_side;
            assign p_v    = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
            assign p_v    = r_v[k-1];
        end

        // Try the next bit and keep it where it fits
        always_comb begin
            w_trial = p_root + BIT;
            if (p_rem >= w_trial) begin
                n_rem  = p_rem - w_trial;
                n_root = (p_root >> 1) + BIT;
            end else begin
                n_rem  = p_rem;
                n_root = p_root >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_root  = r_root[STEPS-1][31:0];
    assign o_side  = r_side[STEPS-1];

endmodule

// ----- rtl/tmbi_cordic.sv -----
// ----------------------------------------------------------------------------
// tmbi_cordic
// Pipelined vectoring CORDIC for atan(r), rounded to a Q2.16 slope.
// ----------------------------------------------------------------------------
module tmbi_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [31:0]     i_root,
    input  tmbi_pkg::t_side i_side,
    output logic            o_valid,
    output logic [17:0]     o_slope,
    output tmbi_pkg::t_side o_side
);

    localparam int unsigned STEPS = tmbi_pkg::CORDIC_STEPS;

    logic signed [49:0] r_x [STEPS];
    logic signed [49:0] r_y [STEPS];
    logic signed [31:0] r_z [STEPS];
    tmbi_pkg::t_side    r_side [STEPS];
    logic [STEPS-1:0]   r_v;

    logic signed [31:0] w_zc;
    logic [31:0]        w_round;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [49:0] p_x, p_y, w_xs, w_ys, n_x, n_y;
        logic signed [31:0] p_z, n_z, w_atan;
        tmbi_pkg::t_side    p_side;
        logic               p_v;

        if (k == 0) begin : g_first
            assign p_x    = 50'sd1 <<< 30;
            assign p_y    = {4'd0, i_root, 14'd0};
            assign p_z    = '0;
            assign p_side = i_side;
            assign p_v    = i_valid;
        end else begin : g_next
            assign p_x    = r_x[k-1];
            assign p_y    = r_y[k-1];
            assign p_z    = r_z[k-1];
            assign p_side = r_side[k-1];
            assign p_v    = r_v[k-1];
        end

        // Rotate toward the x axis and accumulate the angle
        always_comb begin
            w_atan = tmbi_pkg::ATAN_Q30[k];
            w_xs   = p_x >>> k;
            w_ys   = p_y >>> k;
            if (!p_y[49]) begin
                n_x = p_x + w_ys;
                n_y = p_y - w_xs;
                n_z = p_z + w_atan;
            end else begin
                n_x = p_x - w_ys;
                n_y = p_y + w_xs;
                n_z = p_z - w_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= n_x;
                r_y[k]    <= n_y;
                r_z[k]    <= n_z;
                r_side[k] <= p_side;
            end
        end
    end

    // Clamp a negative angle and round half up to Q2.16
    always_comb begin
        w_zc    = r_z[STEPS-1][31] ? '0 : r_z[STEPS-1];
        w_round = {1'b0, w_zc[30:0]} + 32'd8192;
    end

    assign o_valid = r_v[STEPS-1];
    assign o_slope = w_round[31:14];
    assign o_side  = r_side[STEPS-1];

endmodule

// ----- rtl/tmbi_div.sv -----
// ----------------------------------------------------------------------------
// tmbi_div
// Three-lane pipelined divider for the v/(t+|v|) transforms, Q1.16 results.
// ----------------------------------------------------------------------------
module tmbi_div (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  tmbi_pkg::t_cfg                          i_cfg,
    input  logic [17:0]                             i_slope,
    input  tmbi_pkg::t_side                         i_side,
    output logic                                    o_valid,
    output logic [tmbi_pkg::NUM_LANES-1:0][16:0]    o_quot,
    output tmbi_pkg::t_side                         o_side
);

    localparam int unsigned LANES  = tmbi_pkg::NUM_LANES;
    localparam int unsigned STAGES = tmbi_pkg::DIV_STEPS + 1;

    logic [LANES-1:0][31:0] w_num;
    logic [LANES-1:0][23:0] w_thr;
    logic [31:0]            w_habs;

    logic [47:0]        r_rem  [STAGES][LANES];
    logic [32:0]        r_den  [STAGES][LANES];
    logic [16:0]        r_quo  [STAGES][LANES];
    logic               r_zero [STAGES][LANES];
    tmbi_pkg::t_side    r_side [STAGES];
    logic [STAGES-1:0]  r_v;

    // Pick the magnitude and threshold for each lane; unused hrel gives zero
    always_comb begin
        w_habs = i_side.hv[31] ? (32'd0 - i_side.hv) : i_side.hv;
        w_num[tmbi_pkg::LANE_SLOPE] = {14'd0, i_slope};
        w_thr[tmbi_pkg::LANE_SLOPE] = i_cfg.slope_thr;
        w_num[tmbi_pkg::LANE_CURVE] = {1'b0, i_side.cm};
        w_thr[tmbi_pkg::LANE_CURVE] = i_cfg.curve_thr;
        w_num[tmbi_pkg::LANE_HREL]  = i_cfg.hrel_in_use ? w_habs : '0;
        w_thr[tmbi_pkg::LANE_HREL]  = i_cfg.hrel_in_use ? i_cfg.hrel_thr : '0;
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        tmbi_pkg::t_side p_side;
        logic            p_v;

        if (s == 0) begin : g_first
            assign p_side = i_side;
            assign p_v    = i_valid;
        end else begin : g_next
            assign p_side = r_side[s-1];
            assign p_v    = r_v[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= p_side;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [47:0] n_rem;
            logic [32:0] n_den;
            logic [16:0] n_quo;
            logic        n_zero;

            if (s == 0) begin : g_load
                // Load numerator and divisor
                always_comb begin
                    n_den  = {9'd0, w_thr[l]} + {1'b0, w_num[l]};
                    n_rem  = {w_num[l], 16'd0};
                    n_quo  = '0;
                    n_zero = (n_den == '0);
                end
            end else begin : g_bit
                localparam int SHIFT = tmbi_pkg::DIV_STEPS - s;
                logic [49:0] w_sub, w_rem, w_diff;

                // Subtract the shifted divisor where it fits
                always_comb begin
                    w_sub  = {17'd0, r_den[s-1][l]} << SHIFT;
                    w_rem  = {2'd0, r_rem[s-1][l]};
                    w_diff = w_rem - w_sub;
                    n_den  = r_den[s-1][l];
                    n_zero = r_zero[s-1][l];
                    if (w_rem >= w_sub) begin
                        n_rem = w_diff[47:0];
                        n_quo = r_quo[s-1][l] | (17'd1 << SHIFT);
                    end else begin
                        n_rem = r_rem[s-1][l];
                        n_quo = r_quo[s-1][l];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s][l]  <= n_rem;
                    r_den[s][l]  <= n_den;
                    r_quo[s][l]  <= n_quo;
                    r_zero[s][l] <= n_zero;
                end
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quot[l] = r_zero[STAGES-1][l] ? '0 : r_quo[STAGES-1][l];
    end

    assign o_valid = r_v[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule
